>>> rtl/core/stepper_sequencer_with_calibration_core_assert.svh
`ifndef STEPPER_SEQUENCER_WITH_CALIBRATION_CORE_ASSERT_SVH
`define STEPPER_SEQUENCER_WITH_CALIBRATION_CORE_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define SSCAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sscal assertion failed");

// Next-cycle implication, checked only out of reset.
`define SSCAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sscal assertion failed");

`endif

>>> rtl/core/sscal_pkg.sv
package sscal_pkg;

    localparam int SSCAL_LAP_COUNT_WIDTH = 16;
    localparam int SSCAL_NUM_LAPS        = 3;

    localparam int SUM_W = 18;
    localparam int RUN_W = 8;
    localparam int REM_W = RUN_W + SUM_W;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [RUN_W-1:0] RUN_DEFAULT = 8'd8;

    typedef enum logic [1:0] {
        ACT_STEP   = 2'd0,
        ACT_CAL    = 2'd1,
        ACT_RUN    = 2'd2,
        ACT_STATUS = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CAL  = 2'd1,
        MODE_RUN  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STEP     = 3'd1,
        EV_CAL      = 3'd2,
        EV_RUN_DONE = 3'd3,
        EV_UNCAL    = 3'd4,
        EV_BUSY     = 3'd5,
        EV_STATUS   = 3'd6
    } event_t;

    typedef struct packed {
        logic             count_given;
        logic [RUN_W-1:0] run_eighths;
        logic             sensor_level;
        action_t          action;
    } item_t;

    typedef struct packed {
        logic [SUM_W-1:0] lap_sum;
        logic             calibrated;
        logic             busy_res;
        logic [3:0]       coil_pattern;
        event_t           event_res;
    } result_t;

    function automatic logic [3:0] half_step_row(input logic [2:0] idx);
        logic [3:0] row;
        case (idx)
            3'd0:    row = 4'h1;
            3'd1:    row = 4'h3;
            3'd2:    row = 4'h2;
            3'd3:    row = 4'h6;
            3'd4:    row = 4'h4;
            3'd5:    row = 4'hC;
            3'd6:    row = 4'h8;
            3'd7:    row = 4'h9;
            default: row = 4'h0;
        endcase
        return row;
    endfunction

endpackage

>>> rtl/core/sscal_pipe_reg.sv
module sscal_pipe_reg #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    // Take a new beat when empty or when the held one leaves this cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

>>> rtl/core/sscal_engine.sv
module sscal_engine #(
    parameter int LAP_COUNT_WIDTH = sscal_pkg::SSCAL_LAP_COUNT_WIDTH,
    parameter int NUM_LAPS        = sscal_pkg::SSCAL_NUM_LAPS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  sscal_pkg::item_t  item,
    output sscal_pkg::result_t result
);

    import sscal_pkg::*;

    `include "stepper_sequencer_with_calibration_core_assert.svh"

    localparam int LAP_NUM_W = $clog2(NUM_LAPS + 1);
    localparam int SUM_ADD_W = ((LAP_COUNT_WIDTH > SUM_W) ? LAP_COUNT_WIDTH : SUM_W) + 1;
    localparam int RUN_DIV   = 8 * NUM_LAPS;

    mode_t                      mode_reg, mode_next;
    logic [2:0]                 phase_reg, phase_next;
    logic [LAP_NUM_W-1:0]       lap_number_reg, lap_number_next;
    logic                       prev_sensor_reg, prev_sensor_next;
    logic [LAP_COUNT_WIDTH-1:0] lap_steps_reg, lap_steps_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic                       done_reg, done_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [3:0]                 coils_reg, coils_next;

    logic                       busy;
    logic [2:0]                 phase_inc;
    logic [LAP_COUNT_WIDTH-1:0] lap_inc;
    logic [SUM_ADD_W-1:0]       sum_add;
    logic                       fall_edge;
    logic [RUN_W-1:0]           run_n;
    event_t                     ev;

    always_comb
    begin
        busy      = mode_reg inside {MODE_CAL, MODE_RUN};
        phase_inc = phase_reg + 3'd1;
        lap_inc   = (&lap_steps_reg) ? lap_steps_reg : lap_steps_reg + 1'b1;
        sum_add   = SUM_ADD_W'(sum_reg) + SUM_ADD_W'(lap_inc);
        fall_edge = prev_sensor_reg && !item.sensor_level;
        run_n     = item.count_given ? item.run_eighths : RUN_DEFAULT;

        mode_next        = mode_reg;
        phase_next       = phase_reg;
        lap_number_next  = lap_number_reg;
        prev_sensor_next = prev_sensor_reg;
        lap_steps_next   = lap_steps_reg;
        sum_next         = sum_reg;
        done_next        = done_reg;
        rem_next         = rem_reg;
        coils_next       = coils_reg;
        ev               = EV_NONE;

        if (item.action == ACT_STEP)
        begin
            case (mode_reg)
                MODE_CAL:
                begin
                    phase_next       = phase_inc;
                    coils_next       = half_step_row(phase_inc);
                    prev_sensor_next = item.sensor_level;
                    ev               = EV_STEP;
                    if (!fall_edge)
                    begin
                        lap_steps_next = lap_inc;
                    end
                    else if (lap_number_reg == '0)
                    begin
                        lap_number_next = LAP_NUM_W'(1);
                        lap_steps_next  = '0;
                    end
                    else
                    begin
                        lap_steps_next = '0;
                        sum_next = (sum_add > SUM_ADD_W'(SUM_MAX)) ? SUM_MAX
                                                                 : sum_add[SUM_W-1:0];
                        if (lap_number_reg >= LAP_NUM_W'(NUM_LAPS))
                        begin
                            done_next       = 1'b1;
                            mode_next       = MODE_IDLE;
                            lap_number_next = '0;
                            ev              = EV_CAL;
                        end
                        else
                        begin
                            lap_number_next = lap_number_reg + 1'b1;
                        end
                    end
                end
                MODE_RUN:
                begin
                    phase_next = phase_inc;
                    coils_next = half_step_row(phase_inc);
                    // rem holds n*sum not yet covered; each step covers RUN_DIV of it
                    if (rem_reg > REM_W'(RUN_DIV))
                    begin
                        rem_next = rem_reg - REM_W'(RUN_DIV);
                        ev       = EV_STEP;
                    end
                    else
                    begin
                        rem_next   = '0;
                        coils_next = 4'h0;
                        mode_next  = MODE_IDLE;
                        ev         = EV_RUN_DONE;
                    end
                end
                default:
                begin
                    ev = EV_NONE;
                end
            endcase
        end
        else if (busy)
        begin
            ev = EV_BUSY;
        end
        else
        begin
            case (item.action)
                ACT_CAL:
                begin
                    mode_next        = MODE_CAL;
                    prev_sensor_next = item.sensor_level;
                    lap_number_next  = '0;
                    lap_steps_next   = '0;
                    sum_next         = '0;
                end
                ACT_RUN:
                begin
                    if (!done_reg)
                    begin
                        ev = EV_UNCAL;
                    end
                    else if (run_n == '0 || sum_reg == '0)
                    begin
                        rem_next   = '0;
                        coils_next = 4'h0;
                        ev         = EV_RUN_DONE;
                    end
                    else
                    begin
                        rem_next  = REM_W'(run_n) * REM_W'(sum_reg);
                        mode_next = MODE_RUN;
                    end
                end
                ACT_STATUS:
                begin
                    ev = EV_STATUS;
                end
                default:
                begin
                    ev = EV_NONE;
                end
            endcase
        end

        result.coil_pattern = coils_next;
        result.event_res    = ev;
        result.busy_res     = (mode_next == MODE_CAL) || (mode_next == MODE_RUN);
        result.calibrated   = done_next;
        result.lap_sum      = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            phase_reg       <= 3'd0;
            lap_number_reg  <= '0;
            prev_sensor_reg <= 1'b0;
            lap_steps_reg   <= '0;
            sum_reg         <= '0;
            done_reg        <= 1'b0;
            rem_reg         <= '0;
            coils_reg       <= 4'h0;
        end
        else if (step_en)
        begin
            mode_reg        <= mode_next;
            phase_reg       <= phase_next;
            lap_number_reg  <= lap_number_next;
            prev_sensor_reg <= prev_sensor_next;
            lap_steps_reg   <= lap_steps_next;
            sum_reg         <= sum_next;
            done_reg        <= done_next;
            rem_reg         <= rem_next;
            coils_reg       <= coils_next;
        end
    end

    `SSCAL_ASSERT_NOW(a_run_has_work, clk, rst_n, mode_reg == MODE_RUN, rem_reg != '0)
    `SSCAL_ASSERT_NOW(a_run_needs_cal, clk, rst_n, mode_reg == MODE_RUN, done_reg)
    `SSCAL_ASSERT_NEXT(a_cal_sticks, clk, rst_n, done_reg, done_reg)
    `SSCAL_ASSERT_NOW(a_lap_in_range, clk, rst_n, 1'b1,
                      lap_number_reg <= LAP_NUM_W'(NUM_LAPS))

endmodule

>>> rtl/core/stepper_sequencer_with_calibration_core.sv
// Channel | Dir | tdata (low bit up)                            | tuser
// s_axis  | in  | sensor_level, run_eighths, count_given, pad   | action
// m_axis  | out | coil_pattern, busy_res, calibrated, lap_sum   | event_res
//
// One beat in, one beat out; a new beat is taken every cycle unless m_axis stalls.
// Each beat passes the input register, then the step logic into the result register.
// A run is counted down by subtracting 8*NUM_LAPS from n*sum each step tick.
// rst_n clears all sequencer state and both valid bits; no beat is lost on a stall.
// When m_axis stalls, the result register holds and s_axis backs up behind it.
module stepper_sequencer_with_calibration_core #(
    parameter int LAP_COUNT_WIDTH = sscal_pkg::SSCAL_LAP_COUNT_WIDTH,
    parameter int NUM_LAPS        = sscal_pkg::SSCAL_NUM_LAPS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // sensor_level, run_eighths[7:0], count_given, zero pad
    input  logic [1:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // coil_pattern[3:0], busy_res, calibrated, lap_sum[17:0]
    output logic [2:0]  m_axis_tuser   // event_res
);

    import sscal_pkg::*;

    item_t   in_item;
    item_t   stage_item;
    result_t result;
    result_t out_result;
    logic    stage_valid;
    logic    stage_ready;

    always_comb
    begin
        in_item.action       = action_t'(s_axis_tuser);
        in_item.sensor_level = s_axis_tdata[0];
        in_item.run_eighths  = s_axis_tdata[8:1];
        in_item.count_given  = s_axis_tdata[9];
    end

    sscal_pipe_reg #(
        .WIDTH($bits(item_t))
    ) u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (in_item),
        .out_valid(stage_valid),
        .out_ready(stage_ready),
        .out_data (stage_item)
    );

    sscal_engine #(
        .LAP_COUNT_WIDTH(LAP_COUNT_WIDTH),
        .NUM_LAPS       (NUM_LAPS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step_en(stage_valid && stage_ready),
        .item   (stage_item),
        .result (result)
    );

    sscal_pipe_reg #(
        .WIDTH($bits(result_t))
    ) u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid),
        .in_ready (stage_ready),
        .in_data  (result),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (out_result)
    );

    assign m_axis_tdata = {out_result.lap_sum, out_result.calibrated,
                           out_result.busy_res, out_result.coil_pattern};
    assign m_axis_tuser = out_result.event_res;

endmodule
